// ===== design/cpc_pkg.sv =====
package cpc_pkg;

  // Default coordinate width in bits; coordinates are signed fixed point.
  localparam int unsigned CoordWidth = 32;

  // Width of the configuration register index.
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgHalfLength = 2'd0,
    CfgRadius     = 2'd1
  } cfg_idx_e;

endpackage

// ===== design/cylinder_containment_and_projection_top.sv =====
// Chan  Dir  Handshake                Payload
// in    in   in_valid_i/in_stall_o    point_x_i, point_y_i, point_z_i, margin_i
// out   out  out_valid_o/out_stall_i  is_inside_o, all_inside_o, proj_x_o, proj_y_o, proj_z_o
// cfg   in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction enters per cycle while in_stall_o is low; each result passes through
// 2*CW+3 register stages: three front stages, CW square root cells,
// CW-1 divider cells and the output register.
// The whole pipeline moves together: it holds only while a result waits at the
// output and out_stall_i is high, and in_stall_o then stalls the input.
// Reset clears all valid bits and both configuration registers to zero.
module cylinder_containment_and_projection_top #(
  parameter int unsigned CW = cpc_pkg::CoordWidth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [CW-1:0]               point_x_i,
  input  logic signed [CW-1:0]               point_y_i,
  input  logic signed [CW-1:0]               point_z_i,
  input  logic [CW-2:0]                      margin_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               is_inside_o,
  output logic                               all_inside_o,
  output logic signed [CW-1:0]               proj_x_o,
  output logic signed [CW-1:0]               proj_y_o,
  output logic signed [CW-1:0]               proj_z_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [cpc_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [CW-2:0]                      cfg_data_i
);

  // Side data: {is_inside, all_inside, proj_x, sign y, sign z}.
  localparam int unsigned SideW = CW + 4;

  logic en;

  // Configuration registers.
  logic [CW-2:0] hl_q, radius_q;

  // Stage 1: magnitudes and signs.
  logic          v1_q;
  logic [CW-1:0] x1_q, ax1_q, ay1_q, az1_q;
  logic          sx1_q, sy1_q, sz1_q;
  logic [CW-2:0] m1_q;

  // Stage 2: products and the x tests.
  logic            v2_q;
  logic [2*CW-1:0] sq_y2_q, sq_z2_q, rr2_q;
  logic [2*CW-3:0] rm2_q;
  logic [2*CW-2:0] num_y2_q, num_z2_q;
  logic            x_ok2_q, x_all2_q, m_ok2_q, sy2_q, sz2_q;
  logic [CW-1:0]   px2_q;
  logic [CW-2:0]   rmm;

  // Stage 3: sum of squares and the containment flags.
  logic            v3_q;
  logic [2*CW-1:0] rt3_q, rt_sum;
  logic [2*CW-2:0] num_y3_q, num_z3_q;
  logic [SideW-1:0] side3_q;

  // Square root chain.
  logic            sv   [CW+1];
  logic [2*CW-1:0] srem [CW+1];
  logic [CW-1:0]   sroot[CW+1];
  logic [2*CW-2:0] snumy[CW+1];
  logic [2*CW-2:0] snumz[CW+1];
  logic [SideW-1:0] sside[CW+1];

  // Divider chain.
  logic            dv   [CW];
  logic [CW-1:0]   dnorm[CW];
  logic [2*CW-2:0] dremy[CW];
  logic [2*CW-2:0] dremz[CW];
  logic [CW-2:0]   dqy  [CW];
  logic [CW-2:0]   dqz  [CW];
  logic [SideW-1:0] dside[CW];

  // Output register.
  logic          vo_q;
  logic          ins_q, all_q;
  logic [CW-1:0] px_q, py_q, pz_q;
  logic [CW-1:0] py_d, pz_d;

  // The pipeline advances unless a finished result is held by the consumer.
  assign en          = !(vo_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q     <= '0;
      radius_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpc_pkg::CfgHalfLength: hl_q     <= cfg_data_i;
        cpc_pkg::CfgRadius:     radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= dv[CW-1];
    end
  end

  // Stage 1: the most negative coordinate still has a representable magnitude.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q  <= point_x_i;
      sx1_q <= point_x_i[CW-1];
      sy1_q <= point_y_i[CW-1];
      sz1_q <= point_z_i[CW-1];
      ax1_q <= point_x_i[CW-1] ? (~point_x_i + CW'(1)) : point_x_i;
      ay1_q <= point_y_i[CW-1] ? (~point_y_i + CW'(1)) : point_y_i;
      az1_q <= point_z_i[CW-1] ? (~point_z_i + CW'(1)) : point_z_i;
      m1_q  <= margin_i;
    end
  end

  // Stage 2: a margin above the radius leaves (radius - margin) at zero; the
  // sphere test then fails through the margin check anyway.
  assign rmm = (m1_q <= radius_q) ? (radius_q - m1_q) : '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_y2_q  <= {{CW{1'b0}}, ay1_q} * {{CW{1'b0}}, ay1_q};
      sq_z2_q  <= {{CW{1'b0}}, az1_q} * {{CW{1'b0}}, az1_q};
      rr2_q    <= {{(CW+1){1'b0}}, radius_q} * {{(CW+1){1'b0}}, radius_q};
      rm2_q    <= {{(CW-1){1'b0}}, rmm} * {{(CW-1){1'b0}}, rmm};
      num_y2_q <= {{CW{1'b0}}, radius_q} * {{(CW-1){1'b0}}, ay1_q};
      num_z2_q <= {{CW{1'b0}}, radius_q} * {{(CW-1){1'b0}}, az1_q};
      x_ok2_q  <= (ax1_q <= {1'b0, hl_q});
      x_all2_q <= ({1'b0, ax1_q} + {2'b00, m1_q}) <= {2'b00, hl_q};
      m_ok2_q  <= (m1_q <= radius_q);
      sy2_q    <= sy1_q;
      sz2_q    <= sz1_q;
      // Clamp x to the cylinder ends.
      if (ax1_q > {1'b0, hl_q}) begin
        px2_q <= sx1_q ? (~{1'b0, hl_q} + CW'(1)) : {1'b0, hl_q};
      end else begin
        px2_q <= x1_q;
      end
    end
  end

  // Stage 3.
  assign rt_sum = sq_y2_q + sq_z2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt3_q    <= rt_sum;
      num_y3_q <= num_y2_q;
      num_z3_q <= num_z2_q;
      side3_q  <= {x_ok2_q && (rt_sum <= rr2_q),
                   x_all2_q && m_ok2_q && (rt_sum <= {2'b00, rm2_q}),
                   px2_q, sy2_q, sz2_q};
    end
  end

  assign sv[0]    = v3_q;
  assign srem[0]  = rt3_q;
  assign sroot[0] = '0;
  assign snumy[0] = num_y3_q;
  assign snumz[0] = num_z3_q;
  assign sside[0] = side3_q;

  // Each square root cell settles one root bit, most significant first.
  for (genvar k = 0; k < CW; k++) begin : g_sqrt
    cpc_sqrt_cell #(
      .CW     (CW),
      .BIT    (CW - 1 - k),
      .SIDE_W (SideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .num_y_i (snumy[k]),
      .num_z_i (snumz[k]),
      .side_i  (sside[k]),
      .valid_o (sv[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1]),
      .num_y_o (snumy[k+1]),
      .num_z_o (snumz[k+1]),
      .side_o  (sside[k+1])
    );
  end

  assign dv[0]    = sv[CW];
  assign dnorm[0] = sroot[CW];
  assign dremy[0] = snumy[CW];
  assign dremz[0] = snumz[CW];
  assign dqy[0]   = '0;
  assign dqz[0]   = '0;
  assign dside[0] = sside[CW];

  // The norm is at least |y| and |z|, so each quotient is at most the radius
  // and fits in CW-1 bits.
  for (genvar k = 0; k < CW - 1; k++) begin : g_div
    cpc_div_cell #(
      .CW     (CW),
      .BIT    (CW - 2 - k),
      .SIDE_W (SideW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[k]),
      .norm_i  (dnorm[k]),
      .rem_y_i (dremy[k]),
      .rem_z_i (dremz[k]),
      .q_y_i   (dqy[k]),
      .q_z_i   (dqz[k]),
      .side_i  (dside[k]),
      .valid_o (dv[k+1]),
      .norm_o  (dnorm[k+1]),
      .rem_y_o (dremy[k+1]),
      .rem_z_o (dremz[k+1]),
      .q_y_o   (dqy[k+1]),
      .q_z_o   (dqz[k+1]),
      .side_o  (dside[k+1])
    );
  end

  // A point on the axis projects onto (radius, 0); otherwise the signs are restored.
  always_comb begin
    if (dnorm[CW-1] == '0) begin
      py_d = {1'b0, radius_q};
      pz_d = '0;
    end else begin
      py_d = dside[CW-1][1] ? (~{1'b0, dqy[CW-1]} + CW'(1)) : {1'b0, dqy[CW-1]};
      pz_d = dside[CW-1][0] ? (~{1'b0, dqz[CW-1]} + CW'(1)) : {1'b0, dqz[CW-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ins_q <= dside[CW-1][CW+3];
      all_q <= dside[CW-1][CW+2];
      px_q  <= dside[CW-1][CW+1:2];
      py_q  <= py_d;
      pz_q  <= pz_d;
    end
  end

  assign out_valid_o  = vo_q;
  assign is_inside_o  = ins_q;
  assign all_inside_o = all_q;
  assign proj_x_o     = px_q;
  assign proj_y_o     = py_q;
  assign proj_z_o     = pz_q;

  // The input stalls only behind a held result.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // A sphere that fits implies its center fits.
  a_all_implies_inside : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_inside_o) |-> is_inside_o)
    else $error("all_inside set without is_inside");

  // A held result keeps its x and y projections through the stall.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(proj_y_o) && $stable(proj_x_o)))
    else $error("held result changed");

endmodule

// ===== design/cpc_sqrt_cell.sv =====
// One bit of the floored square root; it passes the numerators and side data along.
module cpc_sqrt_cell #(
  parameter int unsigned CW     = cpc_pkg::CoordWidth,
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*CW-1:0]     rem_i,
  input  logic [CW-1:0]       root_i,
  input  logic [2*CW-2:0]     num_y_i,
  input  logic [2*CW-2:0]     num_z_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [2*CW-1:0]     rem_o,
  output logic [CW-1:0]       root_o,
  output logic [2*CW-2:0]     num_y_o,
  output logic [2*CW-2:0]     num_z_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [2*CW:0]   trial;
  logic            take;
  logic            valid_q;
  logic [2*CW-1:0] rem_q, rem_d;
  logic [CW-1:0]   root_q, root_d;
  logic [2*CW-2:0] num_y_q, num_z_q;
  logic [SIDE_W-1:0] side_q;

  // Setting this bit grows the square by root*2^(BIT+1) + 2^(2*BIT).
  always_comb begin
    trial  = ({{(CW+1){1'b0}}, root_i} << (BIT + 1)) | ((2*CW+1)'(1) << (2 * BIT));
    take   = ({1'b0, rem_i} >= trial);
    rem_d  = take ? (rem_i - trial[2*CW-1:0]) : rem_i;
    root_d = take ? (root_i | (CW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      root_q  <= root_d;
      num_y_q <= num_y_i;
      num_z_q <= num_z_i;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign num_y_o = num_y_q;
  assign num_z_o = num_z_q;
  assign side_o  = side_q;

endmodule

// ===== design/cpc_div_cell.sv =====
// One quotient bit of both projection divisions by the norm.
module cpc_div_cell #(
  parameter int unsigned CW     = cpc_pkg::CoordWidth,
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [CW-1:0]       norm_i,
  input  logic [2*CW-2:0]     rem_y_i,
  input  logic [2*CW-2:0]     rem_z_i,
  input  logic [CW-2:0]       q_y_i,
  input  logic [CW-2:0]       q_z_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [CW-1:0]       norm_o,
  output logic [2*CW-2:0]     rem_y_o,
  output logic [2*CW-2:0]     rem_z_o,
  output logic [CW-2:0]       q_y_o,
  output logic [CW-2:0]       q_z_o,
  output logic [SIDE_W-1:0]   side_o
);

  logic [2*CW-1:0] dsh;
  logic            take_y, take_z;
  logic            valid_q;
  logic [CW-1:0]   norm_q;
  logic [2*CW-2:0] rem_y_q, rem_z_q, rem_y_d, rem_z_d;
  logic [CW-2:0]   q_y_q, q_z_q, q_y_d, q_z_d;
  logic [SIDE_W-1:0] side_q;

  always_comb begin
    dsh     = {{CW{1'b0}}, norm_i} << BIT;
    take_y  = ({1'b0, rem_y_i} >= dsh);
    take_z  = ({1'b0, rem_z_i} >= dsh);
    rem_y_d = take_y ? (rem_y_i - dsh[2*CW-2:0]) : rem_y_i;
    rem_z_d = take_z ? (rem_z_i - dsh[2*CW-2:0]) : rem_z_i;
    q_y_d   = take_y ? (q_y_i | ((CW-1)'(1) << BIT)) : q_y_i;
    q_z_d   = take_z ? (q_z_i | ((CW-1)'(1) << BIT)) : q_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q  <= norm_i;
      rem_y_q <= rem_y_d;
      rem_z_q <= rem_z_d;
      q_y_q   <= q_y_d;
      q_z_q   <= q_z_d;
      side_q  <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign norm_o  = norm_q;
  assign rem_y_o = rem_y_q;
  assign rem_z_o = rem_z_q;
  assign q_y_o   = q_y_q;
  assign q_z_o   = q_z_q;
  assign side_o  = side_q;

endmodule
